// ===== sv/rlba_pkg.sv =====
`default_nettype none

package rlba_pkg;

  localparam int BASES         = 4;
  localparam int STRANDS       = 2;
  localparam int FLANK_STATES  = 5;
  localparam int GROUPS        = BASES * STRANDS * FLANK_STATES * FLANK_STATES;
  localparam int GROUP_W       = $clog2(GROUPS);

  localparam logic [2:0] UNKNOWN_FLANK = 3'd4;

  localparam int CMD_W    = 2;
  localparam int BASE_W   = 2;
  localparam int FLANK_W  = 3;
  localparam int TLEN_W   = 4;
  localparam int OBS_W    = 8;
  localparam int VALUE_W  = 16;
  localparam int BEST_W   = 4;
  localparam int RESULT_W = 32;

  localparam int NCOUNT_W   = 5;
  localparam int MAXM_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_LIK   = 2'd0,
    CMD_LOAD_PRIOR = 2'd1,
    CMD_OBSERVE    = 2'd2,
    CMD_FINISH     = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_N_COUNT = 1'd0,
    REG_MAX_M   = 1'd1
  } cfg_reg_e;

  function automatic logic [GROUP_W-1:0] grp_index(logic [BASE_W-1:0] base, logic strand,
                                                   logic [FLANK_W-1:0] lf,
                                                   logic [FLANK_W-1:0] rf);
    return GROUP_W'(((int'(base) * STRANDS + int'(strand)) * FLANK_STATES + int'(lf))
                    * FLANK_STATES + int'(rf));
  endfunction

endpackage

`default_nettype wire

// ===== sv/rlba_if.sv =====
`default_nettype none

interface rlba_in_if import rlba_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [BASE_W-1:0]          query_base;
  logic                       strand;
  logic [FLANK_W-1:0]         left_flank;
  logic [FLANK_W-1:0]         right_flank;
  logic [TLEN_W-1:0]          true_length;
  logic [OBS_W-1:0]           observed_length;
  logic signed [VALUE_W-1:0]  load_value;

  modport source (output valid, command, query_base, strand, left_flank, right_flank,
                  true_length, observed_length, load_value, input ready);
  modport sink   (input valid, command, query_base, strand, left_flank, right_flank,
                  true_length, observed_length, load_value, output ready);
endinterface

interface rlba_out_if import rlba_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [BEST_W-1:0]          best_length;
  logic signed [RESULT_W-1:0] best_score;
  logic                       found;

  modport source (output valid, best_length, best_score, found, input ready);
  modport sink   (input valid, best_length, best_score, found, output ready);
endinterface

interface rlba_cfg_if import rlba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/run_length_bayes_argmax.sv =====
// Load items pass LOAD, then MARK if a likelihood is stored (not for a prior or a dropped one).
// Observation and finish items pass FETCH, then RUN over C = min(n_count, MAX_TRUE_LENGTHS):
// four row-presence reads, then one candidate per cycle through the shared saturating adder.
// A finish delivers its item from DONE, held there while the output stalls; one item at a time.
// Reset clears the sums, the row-presence valid bits and the control state at once;
// n_count resets to 16 and max_m to 15. There is no clearing pass.
`default_nettype none

module run_length_bayes_argmax import rlba_pkg::*; #(
  parameter int MAX_TRUE_LENGTHS     = 16,
  parameter int MAX_OBSERVED_LENGTHS = 16,
  parameter int SCORE_WIDTH          = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlba_cfg_if.sink    cfg_i,
  rlba_in_if.sink     in_i,
  rlba_out_if.source  out_o
);

  localparam int N      = MAX_TRUE_LENGTHS;
  localparam int M      = MAX_OBSERVED_LENGTHS;
  localparam int SW     = SCORE_WIDTH;
  localparam int NIDX   = $clog2(N);
  localparam int MIDX   = $clog2(M);
  localparam int CW     = ($clog2(N + 1) > NCOUNT_W) ? $clog2(N + 1) : NCOUNT_W;
  localparam int LDEPTH = GROUPS * N * M;
  localparam int LAW    = $clog2(LDEPTH);

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_MARK  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_RUN   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [NCOUNT_W-1:0] n_count_q;
  logic [MAXM_W-1:0]   max_m_q;

  cmd_e                      cmd_q;
  logic [BASE_W-1:0]         base_q;
  logic                      strand_q;
  logic [FLANK_W-1:0]        left_q, right_q;
  logic [TLEN_W-1:0]         tlen_q;
  logic [OBS_W-1:0]          obs_q;
  logic signed [VALUE_W-1:0] val_q;

  logic [2:0]    fk_q;
  logic [CW-1:0] n_q;
  logic [N-1:0]  pw_q [4];

  logic            s2_v_q, s2_hit_q;
  logic [NIDX-1:0] s2_n_q;

  logic                found_q;
  logic signed [SW-1:0] best_q;
  logic [NIDX-1:0]     bestn_q;

  logic                       out_v_q;
  logic [BEST_W-1:0]          out_len_q;
  logic signed [RESULT_W-1:0] out_score_q;
  logic                       out_found_q;

  // storage
  logic signed [VALUE_W-1:0] lik_mem [LDEPTH];
  logic [N-1:0]              pres_mem [GROUPS];
  logic [GROUPS-1:0]         pres_v_q;
  logic signed [SW-1:0]      acc_mem [N];
  logic [N-1:0]              acc_v_q;
  logic signed [VALUE_W-1:0] pri_mem [N];

  logic signed [VALUE_W-1:0] lik_rd_q, pri_rd_q;
  logic [N-1:0]              pres_rd_q;
  logic                      pres_rv_q;
  logic signed [SW-1:0]      acc_rd_q;
  logic                      acc_rv_q;

  logic in_acc, out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_v_q || out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // derived fields
  logic [FLANK_W-1:0] left_c, right_c;
  assign left_c  = (left_q > UNKNOWN_FLANK) ? UNKNOWN_FLANK : left_q;
  assign right_c = (right_q > UNKNOWN_FLANK) ? UNKNOWN_FLANK : right_q;

  logic [CW-1:0] nc;
  assign nc = (CW'(n_count_q) > CW'(N)) ? CW'(N) : CW'(n_count_q);

  logic [OBS_W-1:0] m_a, m_b;
  assign m_a = (obs_q < OBS_W'(max_m_q)) ? obs_q : OBS_W'(max_m_q);
  assign m_b = (m_a > OBS_W'(M - 1)) ? OBS_W'(M - 1) : m_a;

  logic load_ok, tlen_ok;
  assign tlen_ok = CW'(tlen_q) < CW'(N);
  assign load_ok = (left_q <= UNKNOWN_FLANK) && (right_q <= UNKNOWN_FLANK) && tlen_ok
                   && ((OBS_W + 1)'(obs_q) < (OBS_W + 1)'(M));

  logic [GROUP_W-1:0] g_load, g_fetch, g_flank, g_unk;
  assign g_load  = grp_index(base_q, strand_q, left_q, right_q);
  assign g_fetch = grp_index(base_q, fk_q[1], fk_q[0] ? UNKNOWN_FLANK : left_c,
                             fk_q[0] ? UNKNOWN_FLANK : right_c);
  assign g_flank = grp_index(base_q, strand_q, left_c, right_c);
  assign g_unk   = grp_index(base_q, strand_q, UNKNOWN_FLANK, UNKNOWN_FLANK);

  logic [NIDX-1:0] n_idx, tlen_idx;
  assign n_idx    = n_q[NIDX-1:0];
  assign tlen_idx = NIDX'(tlen_q);

  logic [N-1:0] pf, pu;
  assign pf = strand_q ? pw_q[2] : pw_q[0];
  assign pu = strand_q ? pw_q[3] : pw_q[1];

  logic issue, hit;
  assign issue = (state_q == ST_RUN) && (n_q < nc);
  assign hit   = (cmd_q == CMD_FINISH) ? ((pw_q[0][n_idx] | pw_q[1][n_idx])
                                          & (pw_q[2][n_idx] | pw_q[3][n_idx]))
                                       : (pf[n_idx] | pu[n_idx]);

  logic [GROUP_W-1:0] lik_g;
  logic [NIDX-1:0]    lik_n;
  logic [MIDX-1:0]    lik_m;
  logic [LAW-1:0]     lik_addr;
  always_comb begin
    if (state_q == ST_LOAD) begin
      lik_g = g_load;
      lik_n = tlen_idx;
      lik_m = obs_q[MIDX-1:0];
    end else begin
      lik_g = pf[n_idx] ? g_flank : g_unk;
      lik_n = n_idx;
      lik_m = m_b[MIDX-1:0];
    end
  end
  assign lik_addr = LAW'((LAW'(lik_g) * LAW'(N) + LAW'(lik_n)) * LAW'(M) + LAW'(lik_m));

  logic lik_we, pres_we, pri_we, acc_we;
  logic [GROUP_W-1:0] pres_raddr;
  logic [N-1:0]       pres_word;
  assign lik_we     = (state_q == ST_LOAD) && (cmd_q == CMD_LOAD_LIK) && load_ok;
  assign pri_we     = (state_q == ST_LOAD) && (cmd_q == CMD_LOAD_PRIOR) && tlen_ok;
  assign pres_we    = (state_q == ST_MARK);
  assign pres_raddr = (state_q == ST_FETCH) ? g_fetch : g_load;
  assign pres_word  = (pres_rv_q ? pres_rd_q : '0) | (N'(1) << tlen_idx);

  // shared saturating adder
  logic signed [SW-1:0]      add_a;
  logic signed [VALUE_W-1:0] add_b;
  logic signed [SW:0]        sum;
  logic signed [SW-1:0]      sat;
  assign add_a = acc_rv_q ? acc_rd_q : '0;
  assign add_b = (cmd_q == CMD_FINISH) ? pri_rd_q : lik_rd_q;
  assign sum   = (SW + 1)'(add_a) + (SW + 1)'(add_b);
  assign sat   = (sum[SW] != sum[SW-1]) ? (sum[SW] ? S_MIN : S_MAX) : sum[SW-1:0];

  assign acc_we = s2_v_q && s2_hit_q && (cmd_q == CMD_OBSERVE);

  logic take_best;
  assign take_best = s2_v_q && s2_hit_q && (cmd_q == CMD_FINISH)
                     && (!found_q || (sat > best_q));

  logic signed [63:0] best_wide;
  logic signed [RESULT_W-1:0] best_clip;
  always_comb begin
    best_wide = 64'(best_q);
    if (best_wide > 64'sd2147483647) begin
      best_wide = 64'sd2147483647;
    end else if (best_wide < -64'sd2147483648) begin
      best_wide = -64'sd2147483648;
    end
    best_clip = best_wide[RESULT_W-1:0];
  end

  logic done_go;
  assign done_go = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(in_i.command) == CMD_LOAD_LIK || cmd_e'(in_i.command) == CMD_LOAD_PRIOR)
          begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_LOAD: begin
        state_d = lik_we ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        state_d = ST_IDLE;
      end
      ST_FETCH: begin
        if (fk_q == 3'd4) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (n_q >= nc) begin
          state_d = (cmd_q == CMD_FINISH) ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_count_q <= NCOUNT_W'(16);
      max_m_q   <= MAXM_W'(15);
      fk_q      <= '0;
      n_q       <= '0;
      s2_v_q    <= 1'b0;
      found_q   <= 1'b0;
      out_v_q   <= 1'b0;
      pres_v_q  <= '0;
      acc_v_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_N_COUNT: n_count_q <= cfg_i.data[NCOUNT_W-1:0];
          REG_MAX_M:   max_m_q   <= cfg_i.data[MAXM_W-1:0];
          default:     n_count_q <= n_count_q;
        endcase
      end
      if (in_acc) begin
        fk_q    <= '0;
        n_q     <= '0;
        found_q <= 1'b0;
      end
      if (state_q == ST_FETCH) begin
        fk_q <= fk_q + 3'd1;
      end
      if (issue) begin
        n_q <= n_q + CW'(1);
      end
      s2_v_q <= issue;
      if (take_best) begin
        found_q <= 1'b1;
      end
      if (pres_we) begin
        pres_v_q[g_load] <= 1'b1;
      end
      if (done_go) begin
        acc_v_q <= '0;
      end else if (acc_we) begin
        acc_v_q[s2_n_q] <= 1'b1;
      end
      if (done_go) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_e'(in_i.command);
      base_q   <= in_i.query_base;
      strand_q <= in_i.strand;
      left_q   <= in_i.left_flank;
      right_q  <= in_i.right_flank;
      tlen_q   <= in_i.true_length;
      obs_q    <= in_i.observed_length;
      val_q    <= in_i.load_value;
    end
    if (state_q == ST_FETCH && fk_q != 3'd0) begin
      pw_q[2'(fk_q - 3'd1)] <= pres_rv_q ? pres_rd_q : '0;
    end
    s2_n_q   <= n_idx;
    s2_hit_q <= hit;
    if (take_best) begin
      best_q  <= sat;
      bestn_q <= s2_n_q;
    end
    if (done_go) begin
      out_len_q   <= found_q ? BEST_W'(bestn_q) : '0;
      out_score_q <= found_q ? best_clip : '0;
      out_found_q <= found_q;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (lik_we) begin
      lik_mem[lik_addr] <= val_q;
    end
    lik_rd_q <= lik_mem[lik_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pres_we) begin
      pres_mem[g_load] <= pres_word;
    end
    pres_rd_q <= pres_mem[pres_raddr];
    pres_rv_q <= pres_v_q[pres_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[s2_n_q] <= sat;
    end
    acc_rd_q <= acc_mem[n_idx];
    acc_rv_q <= acc_v_q[n_idx];
  end

  always_ff @(posedge clk_i) begin
    if (pri_we) begin
      pri_mem[tlen_idx] <= val_q;
    end
    pri_rd_q <= pri_mem[n_idx];
  end

  assign out_o.valid       = out_v_q;
  assign out_o.best_length = out_len_q;
  assign out_o.best_score  = out_score_q;
  assign out_o.found       = out_found_q;

endmodule

`default_nettype wire

// ===== bench/tb_run_length_bayes_argmax.sv =====
`default_nettype none

module tb_run_length_bayes_argmax;
  import rlba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRUE_LENS = 16;
  localparam int OBS_LENS  = 16;
  localparam int ROWS      = GROUPS * TRUE_LENS;
  localparam int UNK       = int'(UNKNOWN_FLANK);
  localparam longint SCORE_HI = 64'sd2147483647;
  localparam longint SCORE_LO = -SCORE_HI - 64'sd1;

  typedef struct packed {
    cmd_e                       command;
    logic [BASE_W-1:0]          query_base;
    logic                       strand;
    logic [FLANK_W-1:0]         left_flank;
    logic [FLANK_W-1:0]         right_flank;
    logic [TLEN_W-1:0]          true_length;
    logic [OBS_W-1:0]           observed_length;
    logic signed [VALUE_W-1:0]  load_value;
  } run_item_t;

  localparam int ITEM_W = $bits(run_item_t);

  typedef struct packed {
    logic [BEST_W-1:0]          best_length;
    logic signed [RESULT_W-1:0] best_score;
    logic                       found;
  } verdict_t;

  typedef struct packed {
    run_item_t it;
    logic      typed;
    verdict_t  want;
  } step_t;

  logic clk;
  logic rst_n;

  rlba_cfg_if cfg_if ();
  rlba_in_if  in_if ();
  rlba_out_if out_if ();

  run_length_bayes_argmax u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic signed [VALUE_W-1:0] lik_mem [ROWS*OBS_LENS];
  bit                        lik_set [ROWS*OBS_LENS];
  bit                        row_on [ROWS];
  logic signed [VALUE_W-1:0] prior_mem [TRUE_LENS];
  bit                        prior_set [TRUE_LENS];
  longint                    acc [TRUE_LENS];
  int                        n_count_q = 16;
  int                        max_m_q   = 15;

  verdict_t pending_best [$];
  step_t    steps [$];
  int       errors     = 0;
  int       work_items = 0;
  int       gap_pct    = 0;
  int       stall_pct  = 0;
  bit       hold_go    = 1'b0;
  bit       hold_on    = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint sat_score(input longint x);
    if (x > SCORE_HI) return SCORE_HI;
    if (x < SCORE_LO) return SCORE_LO;
    return x;
  endfunction

  function automatic int row_of(input int b, s, l, r, n);
    return ((((b * STRANDS + s) * FLANK_STATES + l) * FLANK_STATES + r) * TRUE_LENS + n);
  endfunction

  function automatic int find_row(input int b, s, l, r, n);
    int idx;
    idx = row_of(b, s, l, r, n);
    if (row_on[idx]) return idx;
    idx = row_of(b, s, UNK, UNK, n);
    return row_on[idx] ? idx : -1;
  endfunction

  function automatic int live_lengths();
    return (n_count_q > TRUE_LENS) ? TRUE_LENS : n_count_q;
  endfunction

  function automatic int column_of(input run_item_t it);
    int m;
    m = (int'(it.observed_length) < max_m_q) ? int'(it.observed_length) : max_m_q;
    return (m > OBS_LENS - 1) ? OBS_LENS - 1 : m;
  endfunction

  function automatic bit tally_item(input run_item_t it, output verdict_t v);
    int     b, s, l, r, n, m, row, best_n;
    longint sc, best;
    bit     hit;
    b = int'(it.query_base);
    s = int'(it.strand);
    l = int'(it.left_flank);
    r = int'(it.right_flank);
    v = '0;
    if (it.command == CMD_LOAD_LIK) begin
      if (l <= UNK && r <= UNK && int'(it.observed_length) < OBS_LENS) begin
        row = row_of(b, s, l, r, int'(it.true_length));
        lik_mem[row*OBS_LENS + int'(it.observed_length)] = it.load_value;
        lik_set[row*OBS_LENS + int'(it.observed_length)] = 1'b1;
        row_on[row] = 1'b1;
      end
      return 1'b0;
    end
    if (it.command == CMD_LOAD_PRIOR) begin
      prior_mem[it.true_length] = it.load_value;
      prior_set[it.true_length] = 1'b1;
      return 1'b0;
    end
    if (l > UNK) l = UNK;
    if (r > UNK) r = UNK;
    if (it.command == CMD_OBSERVE) begin
      m = column_of(it);
      for (n = 0; n < live_lengths(); n++) begin
        row = find_row(b, s, l, r, n);
        if (row >= 0) acc[n] = sat_score(acc[n] + longint'(lik_mem[row*OBS_LENS + m]));
      end
      return 1'b0;
    end
    hit = 1'b0;
    best = 0;
    best_n = 0;
    for (n = 0; n < live_lengths(); n++) begin
      if (find_row(b, 0, l, r, n) >= 0 && find_row(b, 1, l, r, n) >= 0) begin
        sc = sat_score(acc[n] + longint'(prior_mem[n]));
        if (!hit || sc > best) begin
          hit = 1'b1;
          best = sc;
          best_n = n;
        end
      end
    end
    for (n = 0; n < TRUE_LENS; n++) acc[n] = 0;
    v.found = hit;
    v.best_length = hit ? BEST_W'(best_n) : '0;
    v.best_score = hit ? RESULT_W'(best) : '0;
    return 1'b1;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_db();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return '0;
      default: return VALUE_W'(-int'($urandom_range(0, 2560)));
    endcase
  endfunction

  // Load that an observation or finish would otherwise read before it was written.
  function automatic bit fill_for(input run_item_t it, output run_item_t fill);
    int b, l, r, n, m, row;
    fill = it;
    b = int'(it.query_base);
    l = (int'(it.left_flank) > UNK) ? UNK : int'(it.left_flank);
    r = (int'(it.right_flank) > UNK) ? UNK : int'(it.right_flank);
    if (it.command == CMD_OBSERVE) begin
      m = column_of(it);
      for (n = 0; n < live_lengths(); n++) begin
        row = find_row(b, int'(it.strand), l, r, n);
        if (row >= 0 && !lik_set[row*OBS_LENS + m]) begin
          fill.command = CMD_LOAD_LIK;
          fill.true_length = TLEN_W'(row % TRUE_LENS);
          fill.right_flank = FLANK_W'((row / TRUE_LENS) % FLANK_STATES);
          fill.left_flank = FLANK_W'((row / (TRUE_LENS * FLANK_STATES)) % FLANK_STATES);
          fill.strand = ((row / (TRUE_LENS * FLANK_STATES * FLANK_STATES)) % STRANDS) != 0;
          fill.query_base = BASE_W'(row / (TRUE_LENS * FLANK_STATES * FLANK_STATES * STRANDS));
          fill.observed_length = OBS_W'(m);
          fill.load_value = rand_db();
          return 1'b1;
        end
      end
    end else if (it.command == CMD_FINISH) begin
      for (n = 0; n < live_lengths(); n++) begin
        if (find_row(b, 0, l, r, n) >= 0 && find_row(b, 1, l, r, n) >= 0 && !prior_set[n])
        begin
          fill.command = CMD_LOAD_PRIOR;
          fill.true_length = TLEN_W'(n);
          fill.load_value = rand_db();
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [FLANK_W-1:0] query_flank();
    case ($urandom_range(0, 9))
      0: return FLANK_W'($urandom_range(5, 7));
      1, 2, 3, 4: return UNKNOWN_FLANK;
      default: return FLANK_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic run_item_t next_random_item();
    run_item_t it;
    int        pick;
    it = run_item_t'(ITEM_W'({$urandom, $urandom}));
    it.query_base = ($urandom_range(0, 4) == 0) ? BASE_W'($urandom_range(0, 3))
                                                : BASE_W'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.command = CMD_LOAD_LIK;
      case ($urandom_range(0, 19))
        0: it.left_flank = FLANK_W'($urandom_range(5, 7));
        1: it.right_flank = FLANK_W'($urandom_range(5, 7));
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          it.left_flank = UNKNOWN_FLANK;
          it.right_flank = UNKNOWN_FLANK;
        end
        default: begin
          it.left_flank = FLANK_W'($urandom_range(0, 1));
          it.right_flank = ($urandom_range(0, 3) == 0) ? UNKNOWN_FLANK
                                                       : FLANK_W'($urandom_range(0, 1));
        end
      endcase
      it.observed_length = ($urandom_range(0, 19) == 0) ? OBS_W'($urandom_range(16, 255))
                                                        : OBS_W'($urandom_range(0, 15));
      it.load_value = rand_db();
    end else if (pick < 36) begin
      it.command = CMD_LOAD_PRIOR;
      it.load_value = rand_db();
    end else begin
      it.command = (pick < 86) ? CMD_OBSERVE : CMD_FINISH;
      it.left_flank = query_flank();
      it.right_flank = query_flank();
      it.observed_length = ($urandom_range(0, 9) < 7) ? OBS_W'($urandom_range(0, 15))
                                                      : OBS_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic add_step(input cmd_e c, input int b, s, l, r, n, o, v,
                          input bit typed, input int bl, sc, fd);
    step_t row;
    row.it.command = c;
    row.it.query_base = BASE_W'(b);
    row.it.strand = s[0];
    row.it.left_flank = FLANK_W'(l);
    row.it.right_flank = FLANK_W'(r);
    row.it.true_length = TLEN_W'(n);
    row.it.observed_length = OBS_W'(o);
    row.it.load_value = VALUE_W'(v);
    row.typed = typed;
    row.want.best_length = BEST_W'(bl);
    row.want.best_score = RESULT_W'(sc);
    row.want.found = fd[0];
    steps.insert(steps.size(), row);
  endtask

  task automatic send_item(input run_item_t it, input bit typed, input verdict_t want);
    verdict_t got;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= it.command;
    in_if.query_base <= it.query_base;
    in_if.strand <= it.strand;
    in_if.left_flank <= it.left_flank;
    in_if.right_flank <= it.right_flank;
    in_if.true_length <= it.true_length;
    in_if.observed_length <= it.observed_length;
    in_if.load_value <= it.load_value;
    if (tally_item(it, got)) pending_best.insert(pending_best.size(), typed ? want : got);
    if (!(it.command == CMD_LOAD_LIK && (it.left_flank > UNKNOWN_FLANK ||
          it.right_flank > UNKNOWN_FLANK || int'(it.observed_length) >= OBS_LENS)))
      work_items++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_N_COUNT) n_count_q = data;
    else max_m_q = data;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_best.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    verdict_t want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_best.size() == 0) begin
          $error("result with none expected: best_length %0d best_score %0d found %0d",
                 out_if.best_length, out_if.best_score, out_if.found);
          errors++;
        end else begin
          want = pending_best.pop_front();
          if (out_if.best_length !== want.best_length) begin
            $error("best_length expected %0d got %0d", want.best_length, out_if.best_length);
            errors++;
          end
          if (out_if.best_score !== want.best_score) begin
            $error("best_score expected %0d got %0d", $signed(want.best_score),
                   out_if.best_score);
            errors++;
          end
          if (out_if.found !== want.found) begin
            $error("found expected %0d got %0d", want.found, out_if.found);
            errors++;
          end
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    run_item_t it;
    run_item_t fix;
    int        ph, nc, mm, phase_end, hold_at;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = '0;
    in_if.query_base = '0;
    in_if.strand = 1'b0;
    in_if.left_flank = '0;
    in_if.right_flank = '0;
    in_if.true_length = '0;
    in_if.observed_length = '0;
    in_if.load_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int n = 0; n < TRUE_LENS; n++) acc[n] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_step(CMD_FINISH,     0, 0, 4, 4, 0,   0,      0, 1, 0,      0, 0);
    add_step(CMD_OBSERVE,    3, 1, 0, 3, 0, 255,      0, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   0, 0, 4, 4, 0,   0, -32768, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   0, 1, 4, 4, 0,   0,      0, 0, 0,      0, 0);
    add_step(CMD_LOAD_PRIOR, 0, 0, 0, 0, 0,   0,      0, 0, 0,      0, 0);
    add_step(CMD_LOAD_PRIOR, 2, 1, 3, 1, 15,  9, -32768, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   1, 1, 7, 4, 3,   2,     -1, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   1, 0, 0, 5, 3,   2,     -1, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   0, 0, 4, 4, 2, 255,     -5, 0, 0,      0, 0);
    add_step(CMD_OBSERVE,    0, 0, 4, 4, 0,   0,      0, 0, 0,      0, 0);
    add_step(CMD_FINISH,     0, 0, 4, 4, 0,   0,      0, 1, 0, -32768, 1);
    add_step(CMD_OBSERVE,    0, 1, 7, 6, 0,   0,      0, 0, 0,      0, 0);
    add_step(CMD_FINISH,     0, 1, 6, 7, 0,   0,      0, 1, 0,      0, 1);
    add_step(CMD_LOAD_LIK,   0, 0, 4, 4, 1,   0,      0, 0, 0,      0, 0);
    add_step(CMD_LOAD_LIK,   0, 1, 4, 4, 1,   0,      0, 0, 0,      0, 0);
    add_step(CMD_LOAD_PRIOR, 0, 0, 0, 0, 1,   0,      0, 0, 0,      0, 0);
    add_step(CMD_FINISH,     0, 0, 4, 4, 0,   0,      0, 1, 0,      0, 1);
    add_step(CMD_LOAD_LIK,   0, 0, 1, 2, 0,   0,   -256, 0, 0,      0, 0);
    add_step(CMD_OBSERVE,    0, 0, 1, 2, 0,   0,      0, 0, 0,      0, 0);
    add_step(CMD_FINISH,     0, 0, 1, 2, 0,   0,      0, 1, 1,      0, 1);
    add_step(CMD_OBSERVE,    2, 0, 3, 0, 7,  15,      0, 0, 0,      0, 0);
    add_step(CMD_FINISH,     3, 1, 0, 0, 0,   0,      0, 1, 0,      0, 0);

    gap_pct = 15;
    stall_pct = 15;
    foreach (steps[i]) send_item(steps[i].it, steps[i].typed, steps[i].want);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nc = 16; mm = 15; end
        1: begin nc = 1;  mm = 0;  end
        2: begin nc = 31; mm = 7;  end
        3: begin nc = 0;  mm = 15; end
        4: begin nc = 16; mm = 0;  end
        6: begin nc = 2;  mm = 15; end
        default: begin
          nc = $urandom_range(1, 16);
          mm = $urandom_range(0, 15);
        end
      endcase
      cfg_write(REG_N_COUNT, nc);
      cfg_write(REG_MAX_M, mm);
      cfg_if.valid <= 1'b0;
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      hold_at = work_items + 30;
      phase_end = work_items + ((ph == 3) ? 20 : 80);
      while (work_items < phase_end) begin
        if (!hold_go && work_items >= hold_at) begin
          hold_go = 1'b1;
        end
        it = next_random_item();
        while (fill_for(it, fix)) send_item(fix, 1'b0, '0);
        send_item(it, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== run_length_bayes_argmax.f =====
sv/rlba_pkg.sv
sv/rlba_if.sv
sv/run_length_bayes_argmax.sv
bench/tb_run_length_bayes_argmax.sv
